### src/dsv_pkg.sv
`default_nettype none

package dsv_pkg;

  localparam int unsigned CFG_ADDR_W  = 4;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned Y_W         = 16;
  localparam int unsigned DIST_W      = 16;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned Q_W         = 17;  // step quotient and steps already reported
  localparam int unsigned STEP_W      = 18;  // new steps of one drag
  localparam int unsigned SUM_W       = 34;  // value plus steps, before range fitting
  localparam int unsigned X_W         = 35;  // value minus range_low
  localparam int unsigned SIZE_W      = 33;  // range size, up to 2**32
  localparam int unsigned DIV_N_W     = 35;
  localparam int unsigned DIV_CNT_W   = 6;
  localparam int unsigned Q_ITERS     = 17;
  localparam int unsigned R_ITERS     = 35;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [VAL_W-1:0]  RANGE_LOW_RST  = 32'd0;
  localparam logic [VAL_W-1:0]  RANGE_HIGH_RST = 32'd99;
  localparam logic              WRAP_MODE_RST  = 1'b0;
  localparam logic [DIST_W-1:0] DIST_STEP_RST  = 16'd1;

  typedef enum logic [1:0] {
    REG_RANGE_LOW  = 2'd0,
    REG_RANGE_HIGH = 2'd1,
    REG_WRAP_MODE  = 2'd2,
    REG_DIST_STEP  = 2'd3
  } reg_idx_e;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_DRAG  = 2'd1,
    OP_STOP  = 2'd2,
    OP_SET   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_Q,
    ST_STEPS,
    ST_FIT,
    ST_DIV_R,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [VAL_W-1:0]  range_low;
    logic [VAL_W-1:0]  range_high;
    logic              wrap_mode;
    logic [DIST_W-1:0] distance_per_step;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic touch_start;
    logic touch_stop;
    logic div_start_q;
    logic take_q;
    logic load_set;
    logic fit_direct;
    logic div_start_r;
    logic take_r;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic touching;
    logic steps_nz;
    logic fit_simple;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### src/dsv_regs.sv
`default_nettype none

module dsv_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dsv_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [dsv_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [dsv_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output dsv_pkg::cfg_t                    cfg_o
);
  import dsv_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_RANGE_LOW:  cfg_d.range_low         = pwdata;
        REG_RANGE_HIGH: cfg_d.range_high        = pwdata;
        REG_WRAP_MODE:  cfg_d.wrap_mode         = pwdata[0];
        REG_DIST_STEP:  cfg_d.distance_per_step = pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RANGE_LOW:  prdata = cfg_q.range_low;
      REG_RANGE_HIGH: prdata = cfg_q.range_high;
      REG_WRAP_MODE:  prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_q.wrap_mode};
      REG_DIST_STEP:  prdata = {{(CFG_DATA_W-DIST_W){1'b0}}, cfg_q.distance_per_step};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_low         <= RANGE_LOW_RST;
      cfg_q.range_high        <= RANGE_HIGH_RST;
      cfg_q.wrap_mode         <= WRAP_MODE_RST;
      cfg_q.distance_per_step <= DIST_STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### src/dsv_div.sv
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module dsv_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [dsv_pkg::DIV_N_W-1:0]     num_i,
  input  logic [dsv_pkg::SIZE_W-1:0]      den_i,
  input  logic [dsv_pkg::DIV_CNT_W-1:0]   iters_i,
  output logic [dsv_pkg::DIV_N_W-1:0]     quo_o,
  output logic [dsv_pkg::SIZE_W-1:0]      rem_o,
  output logic                            done_o
);
  import dsv_pkg::*;

  logic [SIZE_W:0]      rem_q, rem_d, trial;
  logic [DIV_N_W-1:0]   quo_q, quo_d;
  logic [SIZE_W-1:0]    den_q, den_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic                 fits;

  assign trial = {rem_q[SIZE_W-1:0], quo_q[DIV_N_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
      cnt_d = iters_i;
    end else if (cnt_q != '0) begin
      rem_d  = fits ? trial - {1'b0, den_q} : trial;
      quo_d  = {quo_q[DIV_N_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q[SIZE_W-1:0];
  assign done_o = done_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> cnt_q == '0)
    else $error("divider restarted while busy");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < {1'b0, den_q})
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

### src/dsv_dp.sv
`default_nettype none

module dsv_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dsv_pkg::cfg_t                     cfg_i,
  input  logic [dsv_pkg::OP_W-1:0]          in_op_i,
  input  logic [dsv_pkg::Y_W-1:0]           in_y_i,
  input  logic [dsv_pkg::VAL_W-1:0]         in_nv_i,
  input  dsv_pkg::cmd_t                     cmd_i,
  output dsv_pkg::sts_t                     sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dsv_pkg::OUT_TDATA_W-1:0]   out_data_o
);
  import dsv_pkg::*;

  // event state
  logic signed [VAL_W-1:0]  held_q;
  logic signed [Y_W-1:0]    start_y_q;
  logic                     touching_q;
  logic signed [Q_W-1:0]    steps_done_q;

  // per-word working registers
  op_e                      op_q;
  logic signed [Y_W-1:0]    y_q;
  logic signed [VAL_W-1:0]  nv_q;
  logic signed [VAL_W-1:0]  old_q;
  logic signed [SUM_W-1:0]  v_q;
  logic signed [STEP_W-1:0] steps_q;
  logic                     dir_q;
  logic                     div_neg_q;
  logic                     out_valid_q;
  logic [OUT_TDATA_W-1:0]   out_data_q;

  logic signed [VAL_W-1:0]  lo, hi;
  logic signed [SUM_W-1:0]  lo_s, hi_s;
  logic                     inverted;
  logic [DIST_W-1:0]        dist_px;
  logic signed [Q_W-1:0]    diff, diff_mag;
  logic signed [Q_W-1:0]    q_val;
  logic signed [STEP_W-1:0] steps;
  logic signed [SUM_W-1:0]  v_steps;
  logic signed [VAL_W-1:0]  clamp_v;
  logic signed [X_W-1:0]    x, x_mag;
  logic [SIZE_W-1:0]        span, size, r_adj;
  logic [VAL_W-1:0]         held_wrap;

  logic                     div_start, div_done;
  logic [DIV_N_W-1:0]       div_num, div_quo;
  logic [SIZE_W-1:0]        div_den, div_rem;
  logic [DIV_CNT_W-1:0]     div_iters;

  assign lo       = cfg_i.range_low;
  assign hi       = cfg_i.range_high;
  assign lo_s     = {{(SUM_W-VAL_W){lo[VAL_W-1]}}, lo};
  assign hi_s     = {{(SUM_W-VAL_W){hi[VAL_W-1]}}, hi};
  assign inverted = lo > hi;
  // a zero step distance counts as one pixel
  assign dist_px  = (cfg_i.distance_per_step == '0) ? DIST_W'(1) : cfg_i.distance_per_step;

  assign diff     = {start_y_q[Y_W-1], start_y_q} - {y_q[Y_W-1], y_q};
  assign diff_mag = diff[Q_W-1] ? -diff : diff;
  assign q_val    = div_neg_q ? -div_quo[Q_W-1:0] : div_quo[Q_W-1:0];
  assign steps    = {q_val[Q_W-1], q_val} - {steps_done_q[Q_W-1], steps_done_q};
  assign v_steps  = {{(SUM_W-VAL_W){held_q[VAL_W-1]}}, held_q}
                  + {{(SUM_W-STEP_W){steps[STEP_W-1]}}, steps};

  assign clamp_v  = (v_q > hi_s) ? hi : (v_q < lo_s) ? lo : v_q[VAL_W-1:0];

  assign x        = {v_q[SUM_W-1], v_q} - {{(X_W-VAL_W){lo[VAL_W-1]}}, lo};
  assign x_mag    = x[X_W-1] ? -x : x;
  assign span     = {hi[VAL_W-1], hi} - {lo[VAL_W-1], lo};
  assign size     = span + SIZE_W'(1);
  // remainder of a negative offset folds back to the non-negative side
  assign r_adj    = (div_neg_q && div_rem != '0) ? size - div_rem : div_rem;
  assign held_wrap = lo + r_adj[VAL_W-1:0];

  assign div_start = cmd_i.div_start_q | cmd_i.div_start_r;
  assign div_num   = cmd_i.div_start_q ? {diff_mag, {(DIV_N_W-Q_W){1'b0}}} : x_mag;
  assign div_den   = cmd_i.div_start_q ? {{(SIZE_W-DIST_W){1'b0}}, dist_px} : size;
  assign div_iters = cmd_i.div_start_q ? DIV_CNT_W'(Q_ITERS) : DIV_CNT_W'(R_ITERS);

  dsv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .iters_i (div_iters),
    .quo_o   (div_quo),
    .rem_o   (div_rem),
    .done_o  (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= '0;
      start_y_q    <= '0;
      touching_q   <= 1'b0;
      steps_done_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.touch_start) begin
        start_y_q    <= y_q;
        steps_done_q <= '0;
        touching_q   <= 1'b1;
      end
      if (cmd_i.touch_stop) touching_q <= 1'b0;
      if (cmd_i.take_q) steps_done_q <= q_val;
      if (cmd_i.fit_direct) held_q <= inverted ? lo : clamp_v;
      if (cmd_i.take_r) held_q <= held_wrap;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= op_e'(in_op_i);
      y_q   <= in_y_i;
      nv_q  <= in_nv_i;
      old_q <= held_q;
      dir_q <= 1'b0;
    end
    if (cmd_i.div_start_q) div_neg_q <= diff[Q_W-1];
    if (cmd_i.div_start_r) div_neg_q <= x[X_W-1];
    if (cmd_i.take_q) begin
      steps_q <= steps;
      v_q     <= v_steps;
      dir_q   <= !steps[STEP_W-1] && (steps != '0);
    end
    if (cmd_i.load_set) v_q <= {{(SUM_W-VAL_W){nv_q[VAL_W-1]}}, nv_q};
    if (cmd_i.out_load) begin
      out_data_q <= {{(OUT_TDATA_W-VAL_W-3){1'b0}}, touching_q, dir_q,
                     held_q != old_q, held_q};
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.touching   = touching_q;
  assign sts_o.steps_nz   = steps_q != '0;
  assign sts_o.fit_simple = inverted | ~cfg_i.wrap_mode;
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_fit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fit_direct || cmd_i.take_r) && !inverted
      |=> (held_q >= lo && held_q <= hi))
    else $error("fitted value outside range");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while full");

endmodule

`default_nettype wire

### src/dsv_ctrl.sv
`default_nettype none

module dsv_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dsv_pkg::sts_t  sts_i,
  output dsv_pkg::cmd_t  cmd_o
);
  import dsv_pkg::*;

  state_e state_q, state_d;
  cmd_t   cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd        = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts_i.op)
          OP_START: begin
            cmd.touch_start = 1'b1;
            state_d         = ST_OUT;
          end
          OP_DRAG: begin
            // drags without a touch in progress are dropped
            if (sts_i.touching) begin
              cmd.div_start_q = 1'b1;
              state_d         = ST_DIV_Q;
            end else begin
              state_d = ST_OUT;
            end
          end
          OP_STOP: begin
            cmd.touch_stop = 1'b1;
            state_d        = ST_OUT;
          end
          OP_SET: begin
            cmd.load_set = 1'b1;
            state_d      = ST_FIT;
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_DIV_Q: begin
        if (sts_i.div_done) begin
          cmd.take_q = 1'b1;
          state_d    = ST_STEPS;
        end
      end
      ST_STEPS: begin
        state_d = sts_i.steps_nz ? ST_FIT : ST_OUT;
      end
      ST_FIT: begin
        if (sts_i.fit_simple) begin
          cmd.fit_direct = 1'b1;
          state_d        = ST_OUT;
        end else begin
          cmd.div_start_r = 1'b1;
          state_d         = ST_DIV_R;
        end
      end
      ST_DIV_R: begin
        if (sts_i.div_done) begin
          cmd.take_r = 1'b1;
          state_d    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign cmd_o = cmd;

endmodule

`default_nettype wire

### src/drag_step_value_counter.sv
// Drag step value counter.
// Input stream (s_axis_*): one word per touch event. tuser carries the opcode
// (start touch, drag, stop touch, set value); tdata carries touch_y and new_value.
// Output stream (m_axis_*): exactly one word per event with the value after the
// event, a changed flag, the step direction of a drag and the touch state.
// Configuration goes through the APB port (range low/high, wrap mode, step
// distance); the user must write it only while no event is in flight, as the
// block itself does not enforce this. Start, stop and ignored drags go straight
// to the output; a set value and a drag that brings new steps are fitted to the
// range by clamping, or in wrap mode (range not inverted) by a range remainder.
// The shared bit-serial divider runs 17 iterations for the step quotient of a
// drag and 35 for the wrap remainder. One event is processed at a time; the next
// is taken the cycle after the previous result is loaded into the output register.
// Reset clears the value, the touch state and the step count and loads the
// register defaults. A stalled receiver holds the result word; the next event is
// still taken and processed, but its result waits until that word is gone.
`default_nettype none

module drag_step_value_counter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [15:0] touch_y, [47:16] new_value
  input  logic [dsv_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [1:0] opcode
  input  logic [dsv_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] current_value, [32] value_changed, [33] step_direction,
  // [34] touch_active, [39:35] zero
  output logic [dsv_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dsv_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [dsv_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [dsv_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import dsv_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  dsv_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dsv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dsv_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_op_i     (s_axis_tuser),
    .in_y_i      (s_axis_tdata[Y_W-1:0]),
    .in_nv_i     (s_axis_tdata[Y_W+VAL_W-1:Y_W]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire
